>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is low
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger
`define CHK_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/ptnp_pkg.sv
// ---------------------------------------------------------------------------
// ptnp_pkg
// Shared types and constants for the prime test and next-prime unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptnp_pkg;

    localparam int VALUE_BITS = 31;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);
    localparam int SQ_BITS    = VALUE_BITS + 2;
    localparam int Q_DEPTH    = 2;
    localparam int QP_BITS    = $clog2(Q_DEPTH);
    localparam int QC_BITS    = $clog2(Q_DEPTH + 1);

    localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};

    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
    } t_q_head;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

endpackage

>>> rtl/ptnp_front.sv
// ---------------------------------------------------------------------------
// ptnp_front
// Request intake and a short queue toward the search engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptnp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic [ptnp_pkg::VALUE_BITS-1:0] i_value,
    output logic                            busy,
    input  logic                            i_pop,
    output ptnp_pkg::t_q_head               o_head
);

    logic [ptnp_pkg::VALUE_BITS-1:0] r_mem [ptnp_pkg::Q_DEPTH];
    logic [ptnp_pkg::QP_BITS-1:0]    r_wr, r_rd;
    logic [ptnp_pkg::QC_BITS-1:0]    r_cnt;
    logic                            push, pop;

    assign busy = (r_cnt == ptnp_pkg::QC_BITS'(ptnp_pkg::Q_DEPTH));
    assign push = start && !busy;
    assign pop  = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.value = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_value;
    end

endmodule

>>> rtl/ptnp_engine.sv
// ---------------------------------------------------------------------------
// ptnp_engine
// Trial-division test of the value, then search upward for the next prime.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptnp_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptnp_pkg::t_q_head               i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic                            o_is_prime,
    output logic [ptnp_pkg::VALUE_BITS-1:0] o_next_prime,
    output logic                            o_overflow
);

    localparam int VB = ptnp_pkg::VALUE_BITS;
    localparam int SB = ptnp_pkg::SQ_BITS;

    ptnp_pkg::t_state r_state, n_state;

    logic                             r_phase;   // 0: value itself, 1: candidates
    logic                             r_comp;    // divisor found for current candidate
    logic                             r_isp, r_ovf;
    logic [VB-1:0]                    r_n, r_d, r_rem;
    logic [SB-1:0]                    r_sq;
    logic [ptnp_pkg::CNT_BITS-1:0]    r_cnt;

    logic          known, prime;
    logic [VB:0]   rem_sh;
    logic [VB-1:0] rem_next;
    logic          last_cand;

    // Decide the current candidate without division where possible
    always_comb begin
        known = 1'b1;
        prime = 1'b0;
        if (r_n < VB'(2))                      prime = 1'b0;
        else if (r_n < VB'(4))                 prime = 1'b1;
        else if (!r_n[0] || r_comp)            prime = 1'b0;
        else if (r_sq > SB'(r_n))              prime = 1'b1;
        else                                   known = 1'b0;
    end

    assign last_cand = (r_n == ptnp_pkg::VAL_MAX);

    // One restoring remainder step per cycle
    always_comb begin
        rem_sh = {r_rem, r_n[r_cnt]};
        if (rem_sh >= {1'b0, r_d}) rem_next = VB'(rem_sh - {1'b0, r_d});
        else                       rem_next = rem_sh[VB-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptnp_pkg::S_IDLE:  if (i_head.valid) n_state = ptnp_pkg::S_CHECK;
            ptnp_pkg::S_CHECK: begin
                if (!known)                  n_state = ptnp_pkg::S_DIV;
                else if (r_phase && prime)   n_state = ptnp_pkg::S_DONE;
                else if (last_cand)          n_state = ptnp_pkg::S_DONE;
            end
            ptnp_pkg::S_DIV:   if (r_cnt == '0) n_state = ptnp_pkg::S_CHECK;
            ptnp_pkg::S_DONE:  n_state = ptnp_pkg::S_IDLE;
            default:           n_state = ptnp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = (r_state == ptnp_pkg::S_IDLE) && i_head.valid;
        o_valid      = (r_state == ptnp_pkg::S_DONE);
        o_is_prime   = r_isp;
        o_overflow   = r_ovf;
        o_next_prime = r_ovf ? '0 : r_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptnp_pkg::S_IDLE;
            r_phase <= 1'b0;
            r_comp  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ptnp_pkg::S_IDLE: begin
                    r_phase <= 1'b0;
                    r_comp  <= 1'b0;
                end
                ptnp_pkg::S_CHECK: begin
                    if (known && !(r_phase && prime) && !last_cand) begin
                        r_phase <= 1'b1;
                        r_comp  <= 1'b0;
                    end
                end
                ptnp_pkg::S_DIV:
                    if (r_cnt == '0 && rem_next == '0) r_comp <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ptnp_pkg::S_IDLE: begin
                r_n   <= i_head.value;
                r_d   <= VB'(3);
                r_sq  <= SB'(9);
                r_isp <= 1'b0;
                r_ovf <= 1'b0;
            end
            ptnp_pkg::S_CHECK: begin
                if (known) begin
                    if (!r_phase) r_isp <= prime;
                    if (!(r_phase && prime)) begin
                        if (last_cand) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_n  <= r_n + 1'b1;
                            r_d  <= VB'(3);
                            r_sq <= SB'(9);
                        end
                    end
                end else begin
                    r_rem <= '0;
                    r_cnt <= ptnp_pkg::CNT_BITS'(VB - 1);
                end
            end
            ptnp_pkg::S_DIV: begin
                r_rem <= rem_next;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    // advance to the next odd divisor, (d+2)^2 = d^2 + 4d + 4
                    r_d  <= r_d + VB'(2);
                    r_sq <= r_sq + {r_d, 2'b00} + SB'(4);
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/prime_test_and_next_prime_unit.sv
// ---------------------------------------------------------------------------
// prime_test_and_next_prime_unit
// Primality flag and next prime above a 31-bit value by trial division.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_value with start high; the request is taken at
//   a clock edge where busy is low. A two-entry queue holds requests while
//   the engine works, so busy rises only when that queue is full.
//   Result channel: o_valid strobes for one cycle with o_is_prime,
//   o_next_prime and o_overflow; the receiver must take it then, results
//   are never held back.
//   Timing: each odd divisor tried passes through the bit-serial remainder
//   unit in S_DIV and then S_CHECK, and each candidate through S_CHECK once
//   more. A test of n tries up to sqrt(n)/2 divisors, so the time for one
//   request grows with sqrt(n) per candidate and with the prime gap.
//   Requests are served in order, one at a time.
//   Reset: i_rst_n low at a clock edge empties the queue and idles the
//   engine; no result is pending after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_test_and_next_prime_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic [ptnp_pkg::VALUE_BITS-1:0] i_value,
    output logic                            busy,
    output logic                            o_valid,
    output logic                            o_is_prime,
    output logic [ptnp_pkg::VALUE_BITS-1:0] o_next_prime,
    output logic                            o_overflow
);

    ptnp_pkg::t_q_head head;
    logic              pop;

    ptnp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_value (i_value),
        .busy    (busy),
        .i_pop   (pop),
        .o_head  (head)
    );

    ptnp_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_is_prime   (o_is_prime),
        .o_next_prime (o_next_prime),
        .o_overflow   (o_overflow)
    );

endmodule

>>> rtl/ptnp_checker.sv
// ---------------------------------------------------------------------------
// ptnp_checker
// Port-level checks on the busy flag and results of the prime test unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptnp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            busy,
    input logic                            o_valid,
    input logic                            o_is_prime,
    input logic [ptnp_pkg::VALUE_BITS-1:0] o_next_prime,
    input logic                            o_overflow
);

    `CHK_ASSERT(a_ovf_zero, !(o_valid && o_overflow) || (o_next_prime == '0), "ovf nonzero")
    `CHK_ASSERT(a_next_ge2, !(o_valid && !o_overflow) || (o_next_prime >= 2), "next below 2")
    `CHK_ASSERT(a_isp_known, !o_valid || !$isunknown(o_is_prime), "is_prime unknown")
    `CHK_ASSERT(a_busy_known, !$isunknown(busy), "busy unknown")
    `CHK_NEXT(a_strobe_gap, o_valid, !o_valid, "strobe on consecutive cycles")

endmodule

bind prime_test_and_next_prime_unit ptnp_checker u_ptnp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_is_prime   (o_is_prime),
    .o_next_prime (o_next_prime),
    .o_overflow   (o_overflow)
);

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the prime test and next-prime unit.
// Runs a table of directed values, including both ends of the 31-bit range,
// and then random values that are mostly small so the run stays short. A
// trial-division predictor gives the expected result of all but typed rows,
// and a monitor compares each result strobe with the oldest expected result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_BITS = ptnp_pkg::VALUE_BITS;
    localparam logic [VALUE_BITS-1:0] VAL_MAX = ptnp_pkg::VAL_MAX;

    localparam int     RANDOM_REQS = 124;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct packed {
        logic                  is_prime;
        logic [VALUE_BITS-1:0] next_prime;
        logic                  overflow;
    } t_prime_result;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        bit                    typed;
        t_prime_result         answer;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic [VALUE_BITS-1:0] i_value;
    logic                  busy;
    logic                  o_valid;
    logic                  o_is_prime;
    logic [VALUE_BITS-1:0] o_next_prime;
    logic                  o_overflow;

    t_prime_result pending_results[$];
    int            mismatches;
    int            results_seen;
    int            requests_sent;
    longint        cycle_count;

    prime_test_and_next_prime_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_value      (i_value),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_is_prime   (o_is_prime),
        .o_next_prime (o_next_prime),
        .o_overflow   (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit divides_by_none(longint unsigned n);
        longint unsigned d;
        if (n < 2) return 1'b0;
        if (n < 4) return 1'b1;
        if (n[0] == 1'b0) return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_prime_result predict_prime_result(logic [VALUE_BITS-1:0] v);
        t_prime_result   r;
        longint unsigned cand;
        r.is_prime   = divides_by_none(longint'(v));
        r.next_prime = '0;
        r.overflow   = 1'b1;
        cand = longint'(v);
        while (cand < longint'(VAL_MAX)) begin
            cand++;
            if (divides_by_none(cand)) begin
                r.next_prime = cand[VALUE_BITS-1:0];
                r.overflow   = 1'b0;
                break;
            end
        end
        return r;
    endfunction

    // Drive one request and hold it until the unit takes it.
    task automatic send_request(logic [VALUE_BITS-1:0] v, t_prime_result want, int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   = 1'b1;
        i_value = v;
        while (busy) @(negedge i_clk);
        pending_results.push_back(want);
        requests_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return VALUE_BITS'($urandom_range(0, 4095));
        if (pick < 95) return VALUE_BITS'($urandom_range(0, 65535));
        return VALUE_BITS'($urandom_range(0, 1048575));
    endfunction

    always @(posedge i_clk) begin
        t_prime_result want;
        if (i_rst_n && o_valid) begin
            results_seen = results_seen + 1;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                mismatches = mismatches + 1;
            end else begin
                want = pending_results.pop_front();
                if (o_is_prime !== want.is_prime) begin
                    $error("is_prime: expected %0d, got %0d", want.is_prime, o_is_prime);
                    mismatches = mismatches + 1;
                end
                if (o_next_prime !== want.next_prime) begin
                    $error("next_prime: expected %0d, got %0d",
                           want.next_prime, o_next_prime);
                    mismatches = mismatches + 1;
                end
                if (o_overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, o_overflow);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_directed_row        rows[$];
        t_prime_result        want;
        logic [VALUE_BITS-1:0] v;
        int                   gap;
        start         = 1'b0;
        i_value       = '0;
        i_rst_n       = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        requests_sent = 0;
        cycle_count   = 0;

        rows.push_back('{VALUE_BITS'(0), 1'b1, '{1'b0, VALUE_BITS'(2), 1'b0}});
        rows.push_back('{VALUE_BITS'(1), 1'b1, '{1'b0, VALUE_BITS'(2), 1'b0}});
        rows.push_back('{VALUE_BITS'(2), 1'b1, '{1'b1, VALUE_BITS'(3), 1'b0}});
        rows.push_back('{VALUE_BITS'(3), 1'b1, '{1'b1, VALUE_BITS'(5), 1'b0}});
        rows.push_back('{VALUE_BITS'(4), 1'b1, '{1'b0, VALUE_BITS'(5), 1'b0}});
        rows.push_back('{VALUE_BITS'(9), 1'b0, '0});
        rows.push_back('{VALUE_BITS'(25), 1'b0, '0});
        rows.push_back('{VALUE_BITS'(49), 1'b0, '0});
        rows.push_back('{VALUE_BITS'(97), 1'b0, '0});
        rows.push_back('{VALUE_BITS'(113), 1'b0, '0});
        rows.push_back('{VALUE_BITS'(7919), 1'b0, '0});
        rows.push_back('{VALUE_BITS'(65535), 1'b0, '0});
        rows.push_back('{VALUE_BITS'(65536), 1'b0, '0});
        rows.push_back('{VALUE_BITS'(1046527), 1'b0, '0});
        // top of range is itself prime, so nothing lies above it
        rows.push_back('{VAL_MAX, 1'b1, '{1'b1, VALUE_BITS'(0), 1'b1}});
        rows.push_back('{VAL_MAX - 1'b1, 1'b1, '{1'b0, VAL_MAX, 1'b0}});

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            want = rows[k].typed ? rows[k].answer : predict_prime_result(rows[k].value);
            send_request(rows[k].value, want, (k % 3 == 0) ? 0 : $urandom_range(0, 18));
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            // Alternate between stretches with random gaps and back-to-back requests.
            gap = ((n / 20) % 2 == 0) ? $urandom_range(0, 18) : 0;
            if (n == RANDOM_REQS / 2) begin
                start = 1'b0;
                while (pending_results.size() != 0) @(negedge i_clk);
            end
            v = random_value();
            send_request(v, predict_prime_result(v), gap);
        end
        start = 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);

        $display("Sent %0d requests (directed and random), checked %0d results.",
                 requests_sent, results_seen);
        $display("Covered zero, one, small primes, prime squares and both range ends.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/ptnp_pkg.sv
rtl/ptnp_front.sv
rtl/ptnp_engine.sv
rtl/prime_test_and_next_prime_unit.sv
rtl/ptnp_checker.sv
bench/testbench.sv
